### rtl/core/bcs_pkg.sv
// Shared types, constants and the segment decoder for the BCD clock block.
package bcs_pkg;

    // Item kinds carried in the mode field
    typedef enum logic [1:0] {
        KIND_BYTE = 2'd0,
        KIND_TICK = 2'd1,
        KIND_SCAN = 2'd2,
        KIND_NONE = 2'd3
    } kind_t;

    // Display scan
    localparam int SCAN_DIGITS = 4;
    localparam int SCAN_W      = $clog2(SCAN_DIGITS);

    // Characters used by the framer
    localparam logic [7:0] CH_HASH = 8'h23;
    localparam logic [7:0] CH_STAR = 8'h2A;
    localparam logic [7:0] CH_ZERO = 8'h30;
    localparam logic [7:0] CH_NINE = 8'h39;

    // Command frames, first character in the top byte
    localparam logic [47:0] CMD_RST   = "#CRST*";
    localparam logic [55:0] CMD_STOP  = "#CSTOP*";
    localparam logic [63:0] CMD_START = "#CSTART*";
    localparam logic [55:0] CMD_MODE1 = "#MODE1*";
    localparam logic [55:0] CMD_MODE2 = "#MODE2*";
    localparam logic [47:0] CMD_SET   = "#CCHT=";

    // Decoded command from one received byte
    typedef struct packed {
        logic             zero_time;
        logic             stop;
        logic             start;
        logic             view_ms;
        logic             view_hm;
        logic             set_time;
        logic [5:0][3:0]  digits;    // index 0 seconds ones .. 5 hours tens
    } cmd_t;

    // 7-segment pattern, segments in bits 7..1; blank above nine
    function automatic logic [7:0] seg_pattern(input logic [3:0] d);
        logic [7:0] p;
        case (d)
            4'd0:    p = 8'h7E;
            4'd1:    p = 8'h0C;
            4'd2:    p = 8'hB6;
            4'd3:    p = 8'h9E;
            4'd4:    p = 8'hCC;
            4'd5:    p = 8'hDA;
            4'd6:    p = 8'hFA;
            4'd7:    p = 8'h0E;
            4'd8:    p = 8'hFE;
            4'd9:    p = 8'hDE;
            default: p = 8'h00;
        endcase
        return p;
    endfunction

endpackage

### rtl/core/bcs_item_if.sv
// Request channel carrying one input item (kind and received byte).
interface bcs_item_if;
    logic       valid;
    logic       ready;
    logic [1:0] mode;
    logic [7:0] rx_byte;

    modport source (output valid, output mode, output rx_byte, input ready);
    modport sink   (input valid, input mode, input rx_byte, output ready);
endinterface

### rtl/core/bcs_result_if.sv
// Request channel carrying one result item (display drives and blink).
interface bcs_result_if;
    logic       valid;
    logic       ready;
    logic [7:0] segments;
    logic [3:0] digit_enable;
    logic       blink;

    modport source (output valid, output segments, output digit_enable, output blink,
                    input ready);
    modport sink   (input valid, input segments, input digit_enable, input blink,
                     output ready);
endinterface

### rtl/core/bcd_clock_serial_cmd_7seg_scan_top.sv
// Six-digit 24-hour BCD clock with serial command framer and 4-digit scan.
//
// Channels: "item" takes one request per cycle: mode 0 is a received serial
// byte (rx_byte), mode 1 a one-second tick, mode 2 a display scan tick, and
// mode 3 does nothing. "result" returns exactly one request per item with
// the segment pattern, the one-hot digit enable and the blink line as they
// stand after that item.
// Path: an accepted item lands in the input register and is processed
// from there into the state and result registers that carry its result.
// Throughput: one item per cycle while result is not held; the whole update
// is one pass of frame compares, BCD carries and a segment lookup between
// the input register and the state/result registers.
// Reset: time zero, clock running, mm:ss view, scan at digit 0, drives and
// blink zero, frame store empty. No clearing pass is needed.
// Stall: while result is held, the input register keeps one more item and
// item.ready drops only when both the input and result stages are full.
module bcd_clock_serial_cmd_7seg_scan_top
    import bcs_pkg::*;
#(
    parameter int FRAME_LEN = 15
)
(
    input  logic            clk,
    input  logic            rst_n,
    bcs_item_if.sink        item,
    bcs_result_if.source    result
);

    // Input stage
    logic       in_valid_reg;
    logic [1:0] in_mode_reg;
    logic [7:0] in_byte_reg;
    logic       fire;
    logic       res_valid_reg;
    logic       res_valid_next;

    // Clock and display state
    logic [5:0][3:0]   time_reg;
    logic [5:0][3:0]   time_next;
    logic [5:0][3:0]   shown_reg;
    logic [5:0][3:0]   shown_next;
    logic              running_reg;
    logic              running_next;
    logic              hours_view_reg;
    logic              hours_view_next;
    logic [SCAN_W-1:0] scan_pos_reg;
    logic [SCAN_W-1:0] scan_pos_next;
    logic              blink_reg;
    logic              blink_next;
    logic [7:0]        seg_reg;
    logic [7:0]        seg_next;
    logic [3:0]        dig_reg;
    logic [3:0]        dig_next;

    logic [5:0][3:0]   tick_time;
    logic [2:0]        show_idx;
    logic [3:0]        show_digit;
    logic              take_byte;
    cmd_t              cmd;

    assign fire       = in_valid_reg && (!res_valid_reg || result.ready);
    assign item.ready = !in_valid_reg || fire;
    assign take_byte  = fire && (in_mode_reg == KIND_BYTE);

    bcs_frame #(
        .FRAME_LEN (FRAME_LEN)
    ) u_frame (
        .clk     (clk),
        .rst_n   (rst_n),
        .take    (take_byte),
        .rx_byte (in_byte_reg),
        .cmd     (cmd)
    );

    // Counted second: BCD carries and hour wrap
    always_comb
    begin
        tick_time    = time_reg;
        tick_time[0] = tick_time[0] + 4'd1;
        if (tick_time[0] > 4'd9)
        begin
            tick_time[0] = 4'd0;
            tick_time[1] = tick_time[1] + 4'd1;
        end
        if (tick_time[1] > 4'd5)
        begin
            tick_time[1] = 4'd0;
            tick_time[2] = tick_time[2] + 4'd1;
        end
        if (tick_time[2] > 4'd9)
        begin
            tick_time[2] = 4'd0;
            tick_time[3] = tick_time[3] + 4'd1;
        end
        if (tick_time[3] > 4'd5)
        begin
            tick_time[3] = 4'd0;
            tick_time[4] = tick_time[4] + 4'd1;
        end
        if (tick_time[4] > 4'd9)
        begin
            tick_time[4] = 4'd0;
            tick_time[5] = tick_time[5] + 4'd1;
        end
        if ((tick_time[5] > 4'd2) || ((tick_time[5] == 4'd2) && (tick_time[4] > 4'd3)))
        begin
            tick_time = '0;
        end
    end

    // Digit picked by the scan position in the current view
    assign show_idx   = {1'b0, scan_pos_reg} + (hours_view_reg ? 3'd2 : 3'd0);
    always_comb
    begin
        case (show_idx)
            3'd0:    show_digit = shown_reg[0];
            3'd1:    show_digit = shown_reg[1];
            3'd2:    show_digit = shown_reg[2];
            3'd3:    show_digit = shown_reg[3];
            3'd4:    show_digit = shown_reg[4];
            3'd5:    show_digit = shown_reg[5];
            default: show_digit = 4'd0;
        endcase
    end

    // State update for the item in the input register
    always_comb
    begin
        time_next       = time_reg;
        shown_next      = shown_reg;
        running_next    = running_reg;
        hours_view_next = hours_view_reg;
        scan_pos_next   = scan_pos_reg;
        blink_next      = blink_reg;
        seg_next        = seg_reg;
        dig_next        = dig_reg;
        case (kind_t'(in_mode_reg))
            KIND_BYTE:
            begin
                if (cmd.zero_time)
                begin
                    time_next = '0;
                end
                if (cmd.set_time)
                begin
                    time_next = cmd.digits;
                end
                if (cmd.stop)
                begin
                    running_next = 1'b0;
                end
                if (cmd.start)
                begin
                    running_next = 1'b1;
                end
                if (cmd.view_ms)
                begin
                    hours_view_next = 1'b0;
                end
                if (cmd.view_hm)
                begin
                    hours_view_next = 1'b1;
                end
            end
            KIND_TICK:
            begin
                if (running_reg)
                begin
                    time_next  = tick_time;
                    shown_next = tick_time;
                    blink_next = !blink_reg;
                end
            end
            KIND_SCAN:
            begin
                seg_next      = seg_pattern(show_digit);
                dig_next      = 4'b1000 >> scan_pos_reg;
                scan_pos_next = scan_pos_reg + SCAN_W'(1);
            end
            default:
            begin
                seg_next = seg_reg;
            end
        endcase
    end

    // Result valid: set by a processed item, cleared when taken
    always_comb
    begin
        if (fire)
        begin
            res_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            res_valid_next = 1'b0;
        end
        else
        begin
            res_valid_next = res_valid_reg;
        end
    end

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (item.ready)
        begin
            in_valid_reg <= item.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item.ready && item.valid)
        begin
            in_mode_reg <= item.mode;
            in_byte_reg <= item.rx_byte;
        end
    end

    // State and result registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg  <= 1'b0;
            time_reg       <= '0;
            shown_reg      <= '0;
            running_reg    <= 1'b1;
            hours_view_reg <= 1'b0;
            scan_pos_reg   <= '0;
            blink_reg      <= 1'b0;
            seg_reg        <= '0;
            dig_reg        <= '0;
        end
        else
        begin
            res_valid_reg <= res_valid_next;
            if (fire)
            begin
                time_reg       <= time_next;
                shown_reg      <= shown_next;
                running_reg    <= running_next;
                hours_view_reg <= hours_view_next;
                scan_pos_reg   <= scan_pos_next;
                blink_reg      <= blink_next;
                seg_reg        <= seg_next;
                dig_reg        <= dig_next;
            end
        end
    end

    assign result.valid        = res_valid_reg;
    assign result.segments     = seg_reg;
    assign result.digit_enable = dig_reg;
    assign result.blink        = blink_reg;

`ifndef SYNTHESIS
    a_dig_onehot0: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(dig_reg))
        else $error("digit enable has more than one bit set");

    a_scan_step: assert property (@(posedge clk) disable iff (!rst_n)
        fire && (in_mode_reg == KIND_SCAN) |=> scan_pos_reg == $past(scan_pos_reg) + 2'd1)
        else $error("scan position did not advance on a scan tick");

    a_blink_toggle: assert property (@(posedge clk) disable iff (!rst_n)
        fire && (in_mode_reg == KIND_TICK) && running_reg |=> blink_reg != $past(blink_reg))
        else $error("blink did not toggle on a counted second");

    a_hold_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !fire |=> $stable(blink_reg) && $stable(seg_reg) && $stable(time_reg))
        else $error("state changed without a processed item");

    a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
        !in_valid_reg || !res_valid_reg |-> item.ready)
        else $error("input stalled while a stage was free");
`endif

endmodule

### rtl/core/bcs_frame.sv
// Serial command framer: frame store, position counter and command decode.
module bcs_frame
    import bcs_pkg::*;
#(
    parameter int FRAME_LEN = 15
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       take,
    input  logic [7:0] rx_byte,
    output cmd_t       cmd
);

    localparam int PosW = $clog2(FRAME_LEN);

    logic [7:0]      fb_reg [FRAME_LEN];
    logic [PosW-1:0] pos_reg;
    logic [PosW-1:0] pos_next;

    logic [7:0]  fbw [FRAME_LEN];
    logic [63:0] head;
    logic        start_ok;
    logic        is_star;
    logic        at_end;
    logic        digits_ok;

    // Store view with the incoming byte written at the current position
    always_comb
    begin
        for (int k = 0; k < FRAME_LEN; k++)
        begin
            fbw[k] = (pos_reg == PosW'(k)) ? rx_byte : fb_reg[k];
        end
        for (int k = 0; k < 8; k++)
        begin
            head[63 - 8*k -: 8] = fbw[k];
        end
    end

    assign start_ok = (fbw[0] == CH_HASH);
    assign is_star  = (rx_byte == CH_STAR);
    assign at_end   = (pos_reg == PosW'(FRAME_LEN - 1));

    // Time digits for the set-time frame
    always_comb
    begin
        digits_ok = 1'b1;
        for (int j = 0; j < 6; j++)
        begin
            digits_ok = digits_ok && (fbw[6 + j] inside {[CH_ZERO:CH_NINE]});
        end
    end

    // Command decode on the closing star
    always_comb
    begin
        logic fire;
        fire = take && start_ok && is_star;
        cmd.zero_time = fire && (pos_reg == PosW'(5)) && (head[63:16] == CMD_RST);
        cmd.stop      = fire && (pos_reg == PosW'(6)) && (head[63:8] == CMD_STOP);
        cmd.start     = fire && (pos_reg == PosW'(7)) && (head == CMD_START);
        cmd.view_ms   = fire && (pos_reg == PosW'(6)) && (head[63:8] == CMD_MODE1);
        cmd.view_hm   = fire && (pos_reg == PosW'(6)) && (head[63:8] == CMD_MODE2);
        cmd.set_time  = fire && (pos_reg == PosW'(12)) && (head[63:16] == CMD_SET)
                        && digits_ok;
        for (int j = 0; j < 6; j++)
        begin
            cmd.digits[5 - j] = fbw[6 + j][3:0];
        end
    end

    // Position: restart on a bad start, a closing star or a full store
    always_comb
    begin
        if (!start_ok || is_star || at_end)
        begin
            pos_next = '0;
        end
        else
        begin
            pos_next = pos_reg + PosW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
            for (int k = 0; k < FRAME_LEN; k++)
            begin
                fb_reg[k] <= '0;
            end
        end
        else if (take)
        begin
            pos_reg <= pos_next;
            for (int k = 0; k < FRAME_LEN; k++)
            begin
                fb_reg[k] <= fbw[k];
            end
        end
    end

endmodule

### tb/sv/tb_bcd_clock_serial_cmd_7seg_scan_top.sv
// Testbench for the BCD clock block: serial command frames, second ticks and display scan.
import bcs_pkg::*;

module tb_bcd_clock_serial_cmd_7seg_scan_top;
    timeunit 1ns;
    timeprecision 1ps;

    // One display result: segment pattern, digit select and blink line
    typedef struct packed {
        logic [7:0] segments;
        logic [3:0] digit_enable;
        logic       blink;
    } drive_t;

    // Tracks the clock, framer and display state, and holds the drives still to come
    class clock_scoreboard #(int FRAME_LEN = 15);
        drive_t     drive_q[$];
        int         errors;
        logic [3:0] time_now[6];     // 0 seconds ones .. 5 hours tens
        logic [3:0] shown[6];
        bit         running;
        bit         hours_view;
        bit         blink;
        logic [1:0] scan_pos;
        logic [7:0] frame[FRAME_LEN];
        int         frame_pos;
        logic [7:0] seg_drive;
        logic [3:0] dig_drive;
        logic [7:0] glyph[10];

        function new();
            glyph = '{8'h7E, 8'h0C, 8'hB6, 8'h9E, 8'hCC, 8'hDA, 8'hFA, 8'h0E, 8'hFE, 8'hDE};
            errors = 0;
            foreach (time_now[k]) time_now[k] = 4'd0;
            foreach (shown[k]) shown[k] = 4'd0;
            running    = 1'b1;
            hours_view = 1'b0;
            blink      = 1'b0;
            scan_pos   = 2'd0;
            seg_drive  = 8'd0;
            dig_drive  = 4'd0;
            clear_frame();
        endfunction

        function void clear_frame();
            foreach (frame[k]) frame[k] = 8'd0;
            frame_pos = 0;
        endfunction

        function int pending();
            return drive_q.size();
        endfunction

        // Command word holds its first character in the top byte
        function bit frame_is(logic [63:0] cmd, int len, int flen);
            if (flen != len || len > FRAME_LEN)
                return 1'b0;
            for (int k = 0; k < len; k++)
                if (frame[k] != cmd[8*(len-1-k) +: 8])
                    return 1'b0;
            return 1'b1;
        endfunction

        function void run_frame(int flen);
            logic [7:0] d;
            if (frame_is(CMD_RST, 6, flen))
            begin
                foreach (time_now[k]) time_now[k] = 4'd0;
            end
            else if (frame_is(CMD_STOP, 7, flen))
            begin
                running = 1'b0;
            end
            else if (frame_is(CMD_START, 8, flen))
            begin
                running = 1'b1;
            end
            else if (frame_is(CMD_MODE1, 7, flen))
            begin
                hours_view = 1'b0;
            end
            else if (frame_is(CMD_MODE2, 7, flen))
            begin
                hours_view = 1'b1;
            end
            else if (flen == 13 && FRAME_LEN >= 13)
            begin
                // set time: header, six decimal digits, closing star
                for (int k = 0; k < 6; k++)
                    if (frame[k] != CMD_SET[8*(5-k) +: 8])
                        return;
                if (frame[12] != CH_STAR)
                    return;
                for (int k = 6; k < 12; k++)
                    if (frame[k] < CH_ZERO || frame[k] > CH_NINE)
                        return;
                for (int k = 0; k < 6; k++)
                begin
                    d = frame[6+k] - CH_ZERO;
                    time_now[5-k] = d[3:0];
                end
            end
        endfunction

        function void take_byte(logic [7:0] b);
            int p;
            p = frame_pos;
            if (p >= FRAME_LEN)
                p = 0;
            frame[p] = b;
            if (frame[0] != CH_HASH)
            begin
                clear_frame();
            end
            else if (b == CH_STAR)
            begin
                run_frame(p + 1);
                frame_pos = 0;
            end
            else if (p + 1 >= FRAME_LEN)
            begin
                // too long without a star: drop it
                clear_frame();
            end
            else
            begin
                frame_pos = p + 1;
            end
        endfunction

        function void second_tick();
            if (!running)
                return;
            time_now[0] = time_now[0] + 4'd1;
            if (time_now[0] > 9)
            begin
                time_now[0] = 4'd0;
                time_now[1] = time_now[1] + 4'd1;
            end
            if (time_now[1] > 5)
            begin
                time_now[1] = 4'd0;
                time_now[2] = time_now[2] + 4'd1;
            end
            if (time_now[2] > 9)
            begin
                time_now[2] = 4'd0;
                time_now[3] = time_now[3] + 4'd1;
            end
            if (time_now[3] > 5)
            begin
                time_now[3] = 4'd0;
                time_now[4] = time_now[4] + 4'd1;
            end
            if (time_now[4] > 9)
            begin
                time_now[4] = 4'd0;
                time_now[5] = time_now[5] + 4'd1;
            end
            // 24-hour wrap, also catches an out-of-range set time
            if (int'(time_now[5]) * 10 + int'(time_now[4]) >= 24)
                foreach (time_now[k]) time_now[k] = 4'd0;
            blink = ~blink;
            shown = time_now;
        endfunction

        function void scan_tick();
            logic [3:0] d;
            d = shown[scan_pos + (hours_view ? 2 : 0)];
            seg_drive = (d <= 9) ? glyph[d] : 8'd0;
            dig_drive = 4'b1000 >> scan_pos;
            scan_pos  = scan_pos + 2'd1;
        endfunction

        // Accepted request on the item channel
        function void note_item(kind_t kind, logic [7:0] b);
            drive_t exp_drive;
            case (kind)
                KIND_BYTE: take_byte(b);
                KIND_TICK: second_tick();
                KIND_SCAN: scan_tick();
                default: ;
            endcase
            exp_drive.segments     = seg_drive;
            exp_drive.digit_enable = dig_drive;
            exp_drive.blink        = blink;
            drive_q.push_back(exp_drive);
        endfunction

        // Accepted request on the result channel
        function void check_drive(logic [7:0] segments, logic [3:0] digit_enable, logic blk);
            drive_t exp_drive;
            if (drive_q.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result segments %h digit_enable %h blink %b",
                         $time, segments, digit_enable, blk);
                return;
            end
            exp_drive = drive_q.pop_front();
            if (segments !== exp_drive.segments)
            begin
                errors++;
                $display("%0t: segments expected %h actual %h",
                         $time, exp_drive.segments, segments);
            end
            if (digit_enable !== exp_drive.digit_enable)
            begin
                errors++;
                $display("%0t: digit_enable expected %h actual %h",
                         $time, exp_drive.digit_enable, digit_enable);
            end
            if (blk !== exp_drive.blink)
            begin
                errors++;
                $display("%0t: blink expected %b actual %b", $time, exp_drive.blink, blk);
            end
        endfunction
    endclass

    localparam int FRAME_LEN   = 15;
    localparam int ITEM_TARGET = 1600;
    localparam int HOLD_CYCLES = 40;
    localparam int TAIL_CYCLES = 8;
    localparam int WATCHDOG    = 1000;

    typedef enum int {SEL_RST, SEL_STOP, SEL_START, SEL_VIEW_MS, SEL_VIEW_HM} cmd_sel_t;

    logic clk;
    logic rst_n;
    bit   steady;      // no idling on either side while set
    bit   hold_req;    // asks the receiver for one long hold-off
    int   items_sent;
    int   quiet;
    clock_scoreboard #(FRAME_LEN) sb;

    bcs_item_if   item_ch ();
    bcs_result_if res_ch ();

    bcd_clock_serial_cmd_7seg_scan_top #(
        .FRAME_LEN (FRAME_LEN)
    ) u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch.sink),
        .result (res_ch.source)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    function automatic logic [7:0] rnd_byte();
        return 8'($urandom_range(0, 255));
    endfunction

    // Send one request and wait until it is taken
    task automatic send_item(input kind_t kind, input logic [7:0] b);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 5);
        if (gap > 0)
        begin
            item_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_ch.valid   <= 1'b1;
        item_ch.mode    <= kind;
        item_ch.rx_byte <= b;
        do @(posedge clk); while (!item_ch.ready);
        sb.note_item(kind, b);
        items_sent++;
    endtask

    task automatic send_ascii(input string s);
        for (int i = 0; i < s.len(); i++)
            send_item(KIND_BYTE, s[i]);
    endtask

    // Full command frame, or only its first cut bytes when cut is nonzero
    task automatic send_command(input cmd_sel_t sel, input int cut);
        logic [63:0] w;
        int          n;
        case (sel)
            SEL_RST:
            begin
                w = 64'(CMD_RST);
                n = 6;
            end
            SEL_STOP:
            begin
                w = 64'(CMD_STOP);
                n = 7;
            end
            SEL_START:
            begin
                w = 64'(CMD_START);
                n = 8;
            end
            SEL_VIEW_MS:
            begin
                w = 64'(CMD_MODE1);
                n = 7;
            end
            default:
            begin
                w = 64'(CMD_MODE2);
                n = 7;
            end
        endcase
        for (int k = 0; k < ((cut > 0) ? cut : n); k++)
            send_item(KIND_BYTE, w[8*(n-1-k) +: 8]);
    endtask

    // Set-time frame from packed BCD hhmmss; flaw picks a way to break it
    task automatic send_set_time(input logic [23:0] hms, input int flaw);
        logic [7:0] msg[14];
        int         n;
        for (int k = 0; k < 6; k++)
            msg[k] = CMD_SET[8*(5-k) +: 8];
        for (int k = 0; k < 6; k++)
            msg[6+k] = CH_ZERO + 8'(hms[4*(5-k) +: 4]);
        msg[12] = CH_STAR;
        msg[13] = CH_STAR;
        n = 13;
        case (flaw)
            1: msg[$urandom_range(6, 11)] = rnd_byte();
            2:
            begin
                msg[12] = CH_ZERO + 8'($urandom_range(0, 9));
                n = 14;
            end
            3: n = 12;
            4: msg[$urandom_range(1, 5)] = rnd_byte();
            default: ;
        endcase
        for (int k = 0; k < n; k++)
            send_item(KIND_BYTE, msg[k]);
    endtask

    // Random time biased toward carry points
    function automatic logic [23:0] rnd_time();
        logic [3:0] ht, ho, mt, mo, st, so;
        ht = ($urandom_range(0, 7) == 0) ? 4'($urandom_range(0, 9)) : 4'($urandom_range(0, 2));
        if (ht == 2)
            ho = $urandom_range(0, 1) ? 4'd3 : 4'($urandom_range(0, 3));
        else
            ho = $urandom_range(0, 1) ? 4'd9 : 4'($urandom_range(0, 9));
        mt = ($urandom_range(0, 7) == 0) ? 4'($urandom_range(6, 9)) : 4'($urandom_range(0, 5));
        mo = $urandom_range(0, 1) ? 4'd9 : 4'($urandom_range(0, 9));
        st = $urandom_range(0, 1) ? 4'd5 : 4'($urandom_range(0, 5));
        so = $urandom_range(0, 1) ? 4'($urandom_range(7, 9)) : 4'($urandom_range(0, 9));
        return {ht, ho, mt, mo, st, so};
    endfunction

    // Frame of 15 bytes: dropped when full, or ended by a star at the last slot
    task automatic send_long_frame(input bit star_last);
        logic [7:0] b;
        send_item(KIND_BYTE, CH_HASH);
        for (int k = 1; k < FRAME_LEN; k++)
        begin
            b = rnd_byte();
            if (b == CH_STAR)
                b = CH_HASH;
            if (k == FRAME_LEN - 1 && star_last)
                b = CH_STAR;
            send_item(KIND_BYTE, b);
        end
    endtask

    task automatic send_scans(input int n);
        repeat (n) send_item(KIND_SCAN, rnd_byte());
    endtask

    // Receiver holds off while the sender keeps offering, so the input stalls
    task automatic stall_burst();
        bit keep;
        keep     = steady;
        steady   = 1'b1;
        hold_req = 1'b1;
        repeat (30) send_item($urandom_range(0, 1) ? KIND_SCAN : KIND_TICK, rnd_byte());
        steady = keep;
    endtask

    task automatic run_directed();
        send_scans(1);
        send_item(KIND_NONE, 8'hFF);
        send_item(KIND_BYTE, 8'h00);      // bad frame start
        send_item(KIND_BYTE, 8'hFF);
        send_set_time(24'h235958, 0);
        send_item(KIND_TICK, 8'h00);
        send_item(KIND_TICK, 8'hFF);      // midnight wrap
        send_scans(4);
        send_command(SEL_VIEW_HM, 0);
        send_scans(4);
        send_command(SEL_STOP, 0);
        send_item(KIND_TICK, rnd_byte()); // stopped clock
        send_command(SEL_START, 0);
        send_item(KIND_TICK, rnd_byte());
        send_set_time(24'h995959, 0);     // hours out of range, cleared on the tick
        send_item(KIND_TICK, rnd_byte());
        send_command(SEL_RST, 0);
        send_item(KIND_TICK, rnd_byte());
        send_ascii("#CCHT=12a456*");
        send_ascii("#CCHT=1234567*");
        send_ascii("#XYZ*");
        send_long_frame(1'b0);
        send_long_frame(1'b1);
        send_ascii("*");
        send_command(SEL_VIEW_MS, 0);
        send_scans(4);
    endtask

    task automatic run_random();
        int       pick;
        bit       held_a, held_b, drained;
        cmd_sel_t sel;
        held_a  = 1'b0;
        held_b  = 1'b0;
        drained = 1'b0;
        while (items_sent < ITEM_TARGET)
        begin
            if (!held_a && items_sent >= 400)
            begin
                held_a = 1'b1;
                stall_burst();
            end
            if (!held_b && items_sent >= 1200)
            begin
                held_b = 1'b1;
                stall_burst();
            end
            // sender pause until the block has drained
            if (!drained && items_sent >= 800)
            begin
                drained = 1'b1;
                item_ch.valid <= 1'b0;
                while (sb.pending() != 0) @(posedge clk);
            end
            if ($urandom_range(0, 19) == 0)
                steady = ~steady;

            pick = $urandom_range(0, 99);
            sel  = cmd_sel_t'($urandom_range(0, 4));
            if (sel == SEL_STOP && $urandom_range(0, 1))
                sel = SEL_START;
            if (pick < 28)
                send_scans($urandom_range(1, 8));
            else if (pick < 52)
                repeat ($urandom_range(1, 10)) send_item(KIND_TICK, rnd_byte());
            else if (pick < 64)
                send_set_time(rnd_time(), 0);
            else if (pick < 76)
                send_command(sel, 0);
            else if (pick < 84)
                send_set_time(rnd_time(), $urandom_range(1, 4));
            else if (pick < 88)
            begin
                send_command(sel, $urandom_range(1, 5));
                if ($urandom_range(0, 1))
                    send_item(KIND_BYTE, CH_STAR);
            end
            else if (pick < 96)
            begin
                repeat ($urandom_range(1, 3)) send_item(KIND_BYTE, rnd_byte());
                send_item(KIND_NONE, rnd_byte());
            end
            else
                send_long_frame($urandom_range(0, 1));
        end
    endtask

    // Result side: random stalls, one long hold-off on request
    initial
    begin
        int gap;
        res_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_req)
            begin
                gap      = HOLD_CYCLES;
                hold_req = 1'b0;
            end
            else
                gap = steady ? 0 : $urandom_range(0, 5);
            if (gap > 0)
            begin
                res_ch.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            res_ch.ready <= 1'b1;
            do @(posedge clk); while (!res_ch.valid);
            sb.check_drive(res_ch.segments, res_ch.digit_enable, res_ch.blink);
        end
    end

    // Watchdog on cycles with no request taken on either channel
    always @(posedge clk)
    begin
        if (!rst_n || (item_ch.valid && item_ch.ready) || (res_ch.valid && res_ch.ready))
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet >= WATCHDOG)
        begin
            $display("tb_bcd_clock_serial_cmd_7seg_scan_top: FAIL");
            $finish;
        end
    end

    initial
    begin
        sb              = new();
        rst_n           = 1'b0;
        steady          = 1'b0;
        hold_req        = 1'b0;
        items_sent      = 0;
        item_ch.valid   = 1'b0;
        item_ch.mode    = KIND_NONE;
        item_ch.rx_byte = 8'h00;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_directed();
        run_random();

        // drain and let the pipeline settle
        item_ch.valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("tb_bcd_clock_serial_cmd_7seg_scan_top: PASS");
        else
            $display("tb_bcd_clock_serial_cmd_7seg_scan_top: FAIL");
        $finish;
    end
endmodule
